FILE: rtl/block_mean_sliding_max_level_defines.svh
// Assertion macros shared by the level meter RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef BLOCK_MEAN_SLIDING_MAX_LEVEL_DEFINES_SVH
`define BLOCK_MEAN_SLIDING_MAX_LEVEL_DEFINES_SVH

// Check an invariant at every clock edge outside reset.
`define BMSML_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next.
`define BMSML_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: rtl/bmsml_pkg.sv
// Package for the sliding window maximum level meter.
// Holds sizing constants, derived widths and the shared subtractor result type.
`timescale 1ns / 1ps
package bmsml_pkg;

	localparam int WINDOW_DEPTH = 100;
	localparam int MAX_FRAMES   = 4096;

	localparam int SAMPLE_W = 16;
	localparam int SCALE_W  = 16;
	localparam int MEAN_W   = 17;
	localparam int LEVEL_W  = 17;
	localparam int FRAC_W   = 15;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;

	localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W  = $clog2(64'(MAX_FRAMES) * 64'd65536 + 64'd1);
	localparam int BIT_W  = (SUM_W > 1) ? $clog2(SUM_W) : 1;
	localparam int WIN_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int ALU_W  = (CNT_W + 1 > MEAN_W) ? CNT_W + 1 : MEAN_W;
	localparam int PROD_W = MEAN_W + SCALE_W;

	typedef struct packed {
		logic [ALU_W-1:0] diff;
		logic             borrow;
	} alu_res_t;

endpackage

FILE: rtl/bmsml_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps
module bmsml_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 100,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/bmsml_sub.sv
// Shared subtract and compare unit: a minus b with borrow out.
// Depends on bmsml_pkg for the operand width and result type.
`timescale 1ns / 1ps
module bmsml_sub import bmsml_pkg::*; (
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output alu_res_t         res
);

	logic [ALU_W:0] full;

	assign full       = {1'b0, a} - {1'b0, b};
	assign res.diff   = full[ALU_W-1:0];
	assign res.borrow = full[ALU_W];

endmodule

FILE: rtl/block_mean_sliding_max_level.sv
// Top level of the sliding window maximum level meter: sequencer and datapath.
// Depends on bmsml_pkg, bmsml_sub, bmsml_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "block_mean_sliding_max_level_defines.svh"

// Channel   Handshake              Payload
// in        in_valid / in_ready    left_sample, right_sample, last_frame
// out       out_valid / out_ready  level_out
// cfg       cfg_valid / cfg_ready  cfg_data (full scale factor)
//
// A frame that does not close a buffer leaves in_ready high.
// A closing frame runs the divide over SUM_W quotient bits, a window write, a scan of
// each filled window entry, a drain and a multiply, with in_ready low throughout.
// The restoring divide and the window scan share one subtractor.
// arst_n clears counters, sums, window fill, write slot and scale (to 1000).
// A result held by a stalled out_ready holds the next closing frame, and the input with it.
module block_mean_sliding_max_level import bmsml_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       last_frame,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [LEVEL_W-1:0]         level_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [SCALE_W-1:0]         cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_WR    = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;

	// Magnitude of a Q1.15 sample; the most negative code maps to 32768.
	function automatic logic [SAMPLE_W:0] mag16(input logic [SAMPLE_W-1:0] v);
		logic [SAMPLE_W:0] ext;
		ext = {1'b0, v};
		mag16 = v[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - ext : ext;
	endfunction

	logic [2:0]         state_q;
	logic [SCALE_W-1:0] scale_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   dvd_q;     // dividend, quotient shifts in at the bottom
	logic [CNT_W-1:0]   divisor_q;
	logic [CNT_W-1:0]   rem_q;
	logic [BIT_W-1:0]   bit_q;
	logic [WIN_AW-1:0]  slot_q;
	logic [FILL_W-1:0]  fill_q;
	logic [WIN_AW-1:0]  idx_q;
	logic               rd_vld_s1;
	logic [MEAN_W-1:0]  best_q;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;

	logic               in_fire;
	logic               room;
	logic [SUM_W-1:0]   sum_next;
	logic [CNT_W-1:0]   cnt_next;
	logic [CNT_W:0]     rem_shift;
	logic [ALU_W-1:0]   alu_a;
	logic [ALU_W-1:0]   alu_b;
	alu_res_t           alu_res;
	logic [MEAN_W-1:0]  mean;
	logic [MEAN_W-1:0]  win_rdata;
	logic               ram_we;
	logic               scan_last;
	logic               out_load;
	logic [PROD_W-1:0]  prod;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign level_out = level_q;

	// Accumulate only while the frame count has room.
	assign room     = (cnt_q < CNT_W'(MAX_FRAMES));
	assign sum_next = room ? sum_q + SUM_W'(mag16(left_sample)) + SUM_W'(mag16(right_sample))
	                       : sum_q;
	assign cnt_next = room ? cnt_q + CNT_W'(1) : cnt_q;

	// Shared subtractor: divide step while dividing, window compare otherwise.
	assign rem_shift = {rem_q, dvd_q[SUM_W-1]};
	always_comb begin
		if (state_q == ST_DIV) begin
			alu_a = ALU_W'(rem_shift);
			alu_b = ALU_W'(divisor_q);
		end else begin
			alu_a = ALU_W'(best_q);
			alu_b = ALU_W'(win_rdata);
		end
	end

	bmsml_sub u_sub (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign mean   = dvd_q[MEAN_W-1:0];
	assign ram_we = (state_q == ST_WR);

	bmsml_ram #(
		.WIDTH (MEAN_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (mean),
		.raddr (idx_q),
		.rdata (win_rdata)
	);

	assign scan_last = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);
	assign out_load  = (state_q == ST_MUL) && (!out_valid_q || out_ready);
	assign prod      = PROD_W'(best_q) * PROD_W'(scale_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_q     <= SCALE_RESET;
			sum_q       <= '0;
			cnt_q       <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			bit_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				scale_q <= cfg_data;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (last_frame) begin
							// Close the buffer: clear the accumulators, start the divide.
							sum_q   <= '0;
							cnt_q   <= '0;
							bit_q   <= BIT_W'(SUM_W - 1);
							state_q <= ST_DIV;
						end else begin
							sum_q <= sum_next;
							cnt_q <= cnt_next;
						end
					end
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						state_q <= ST_WR;
					end else begin
						bit_q <= bit_q - BIT_W'(1);
					end
				end
				ST_WR: begin
					// Advance the write slot and the fill count, restart the scan.
					slot_q <= (slot_q == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + WIN_AW'(1);
					if (fill_q != FILL_W'(WINDOW_DEPTH)) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + WIN_AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// Hold until the output register is free.
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in_fire && last_frame) begin
			dvd_q     <= sum_next;
			divisor_q <= cnt_next;
			rem_q     <= '0;
		end else if (state_q == ST_DIV) begin
			// Restoring divide: one quotient bit per cycle.
			if (!alu_res.borrow) begin
				rem_q <= alu_res.diff[CNT_W-1:0];
			end else begin
				rem_q <= rem_shift[CNT_W-1:0];
			end
			dvd_q <= {dvd_q[SUM_W-2:0], ~alu_res.borrow};
		end
		if (state_q == ST_WR) begin
			best_q <= mean;
		end else if (rd_vld_s1 && alu_res.borrow) begin
			best_q <= win_rdata;
		end
		if (out_load) begin
			level_q <= prod[FRAC_W +: LEVEL_W];
		end
	end

	`BMSML_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_FRAMES), "frame count above limit")
	`BMSML_ASSERT(a_win_bound, (fill_q <= FILL_W'(WINDOW_DEPTH)) && (slot_q < WIN_AW'(WINDOW_DEPTH)), "window pointer out of range")
	`BMSML_ASSERT_NEXT(a_last_div, in_fire && last_frame, state_q == ST_DIV, "closing frame did not start divide")
	`BMSML_ASSERT_NEXT(a_mul_hold, (state_q == ST_MUL) && out_valid_q && !out_ready, (state_q == ST_MUL) && out_valid_q, "result overwrote pending output")

endmodule

FILE: sim/block_mean_sliding_max_level_tb.sv
// Testbench for the sliding window maximum level meter: directed and random stereo frames.
// Predicts each level from its own model of the buffer sum, the mean window and the scale.
// Depends on bmsml_pkg and the block_mean_sliding_max_level RTL.
`timescale 1ns / 1ps
module block_mean_sliding_max_level_tb import bmsml_pkg::*; ();

	localparam int SETTLE_CYCLES  = 160;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       last;
	} frame_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] left_sample  = '0;
	logic signed [SAMPLE_W-1:0] right_sample = '0;
	logic                       last_frame   = 1'b0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic [LEVEL_W-1:0]         level_out;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic [SCALE_W-1:0]         cfg_data     = '0;

	// Frames waiting to go out, and levels waiting to come back.
	frame_t             frame_fifo[$];
	logic [LEVEL_W-1:0] level_expect_q[$];
	frame_t             frame_on_bus;

	// Predictor state: running buffer, window of block means, scale.
	logic [SUM_W-1:0]   buf_sum    = '0;
	logic [CNT_W-1:0]   buf_frames = '0;
	logic [MEAN_W-1:0]  mean_hist[WINDOW_DEPTH];
	logic [FILL_W-1:0]  hist_fill  = '0;
	logic [WIN_AW-1:0]  hist_slot  = '0;
	logic [SCALE_W-1:0] scale_now  = SCALE_RESET;

	// Traffic shaping, set per phase by the stimulus.
	bit sender_smooth = 1'b0;
	bit sink_smooth   = 1'b0;
	int burst_left    = 0;
	int gap_left      = 0;
	int stall_left    = 0;

	int                 error_count = 0;
	int                 idle_cycles = 0;
	logic [LEVEL_W-1:0] want_level;

	block_mean_sliding_max_level dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_frame   (last_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.level_out    (level_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [MEAN_W-1:0] sample_mag(logic signed [SAMPLE_W-1:0] s);
		int v;
		v = s;
		return MEAN_W'(v < 0 ? -v : v);
	endfunction

	// Fold one accepted frame into the buffer; on the closing frame push its mean
	// into the window and queue the expected level.
	function automatic void account_frame(frame_t f);
		logic [SUM_W-1:0]  mean_full;
		logic [MEAN_W-1:0] mean;
		logic [MEAN_W-1:0] best;
		logic [PROD_W-1:0] prod;
		// Stop accumulating once the buffer holds MAX_FRAMES frames.
		if (buf_frames < CNT_W'(MAX_FRAMES)) begin
			buf_sum    = buf_sum + SUM_W'(sample_mag(f.left)) + SUM_W'(sample_mag(f.right));
			buf_frames = buf_frames + CNT_W'(1);
		end
		if (f.last) begin
			mean_full  = buf_sum / SUM_W'(buf_frames);
			mean       = mean_full[MEAN_W-1:0];
			buf_sum    = '0;
			buf_frames = '0;
			mean_hist[hist_slot] = mean;
			hist_slot = (hist_slot == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : hist_slot + WIN_AW'(1);
			if (hist_fill < FILL_W'(WINDOW_DEPTH))
				hist_fill = hist_fill + FILL_W'(1);
			best = mean;
			for (int i = 0; i < WINDOW_DEPTH; i++)
				if (i < hist_fill && mean_hist[i] > best)
					best = mean_hist[i];
			prod = PROD_W'(best) * PROD_W'(scale_now);
			level_expect_q.push_back(prod[FRAC_W +: LEVEL_W]);
		end
	endfunction

	function automatic void queue_frame(logic signed [SAMPLE_W-1:0] l,
			logic signed [SAMPLE_W-1:0] r, logic last);
		frame_t f;
		f.left  = l;
		f.right = r;
		f.last  = last;
		frame_fifo.push_back(f);
	endfunction

	// Mostly uniform within +/-amp, now and then a corner value.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(int amp);
		int v;
		if ($urandom_range(0, 15) == 0) begin
			case ($urandom_range(0, 3))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				default: v = -1;
			endcase
		end else begin
			v = int'($urandom_range(0, 2 * amp)) - amp;
			if (v > 32767)
				v = 32767;
		end
		return SAMPLE_W'(v);
	endfunction

	function automatic void queue_buffer(int len, int amp);
		for (int i = 0; i < len; i++)
			queue_frame(pick_sample(amp), pick_sample(amp), i == len - 1);
	endfunction

	// Wait until every frame is sent and every level is back, then let a
	// closing frame that may still be in flight finish.
	task automatic drain_and_settle();
		do @(posedge clk);
		while (frame_fifo.size() != 0 || in_valid || level_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(logic [SCALE_W-1:0] v);
		drain_and_settle();
		@(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		scale_now = v;
	endtask

	// Frame driver: bursts of random length separated by random gaps, unless the phase sends smooth.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				account_frame(frame_on_bus);
			// Hold the payload while a transaction is pending.
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (frame_fifo.size() > 0) begin
					frame_on_bus = frame_fifo.pop_front();
					left_sample  <= frame_on_bus.left;
					right_sample <= frame_on_bus.right;
					last_frame   <= frame_on_bus.last;
					in_valid     <= 1'b1;
					if (!sender_smooth) begin
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 30);
							gap_left   = $urandom_range(1, 12);
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Level sink: random stalls of random length unless the phase runs smooth.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (sink_smooth) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 19);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Level monitor: compare each transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (level_expect_q.size() == 0) begin
				$display("%0t: level_out %0d arrived with no level expected", $time, level_out);
				error_count++;
			end else begin
				want_level = level_expect_q.pop_front();
				if (level_out !== want_level) begin
					$display("%0t: level_out expected %0d actual %0d",
						$time, want_level, level_out);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run after too many cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("block_mean_sliding_max_level verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int len;
		int amp;
		int queued;
		int buf_idx;
		int pick;
		logic [SCALE_W-1:0] scale_pick;

		buf_idx = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Block means at the reset scale, zero buffer included; the third mean falls below the second.
		queue_frame('0, '0, 1'b1);
		queue_frame(-16'sd1, 16'sd1, 1'b0);
		queue_frame(16'sd20000, -16'sd20000, 1'b1);
		queue_frame(16'sd1, '0, 1'b0);
		queue_frame(16'sd1, '0, 1'b0);
		queue_frame(16'sd20001, 16'sd1, 1'b1);
		queue_frame(S_MAX, S_MIN, 1'b1);
		queue_frame(S_MIN, S_MIN, 1'b1);

		// Full-scale mean at the largest scale gives the top level.
		write_scale('1);
		queue_frame(S_MIN, S_MIN, 1'b1);
		queue_frame('0, '0, 1'b0);
		queue_frame('0, '0, 1'b1);

		write_scale('0);
		queue_frame(16'sd12345, -16'sd12345, 1'b1);
		queue_frame(S_MAX, S_MAX, 1'b0);

		// Random phases: short buffers with a falling envelope so the window
		// maximum keeps sliding out, plus occasional loud spikes.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: scale_pick = SCALE_W'($urandom_range(0, 65535));
				1: scale_pick = '1;
				2: scale_pick = 16'd1;
				default: scale_pick = SCALE_W'($urandom_range(0, 65535));
			endcase
			write_scale(scale_pick);
			sender_smooth = (ph >= 2);
			sink_smooth   = (ph == 1 || ph == 2);
			queued = 0;
			while (queued < 150) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					len = $urandom_range(1, 3);
				else if (pick < 97)
					len = $urandom_range(4, 10);
				else
					len = $urandom_range(11, 40);
				if ($urandom_range(0, 19) == 0)
					amp = 32768;
				else
					amp = 32768 - (buf_idx % 128) * 250;
				queue_buffer(len, amp);
				queued += len;
				buf_idx++;
			end
			// Leave a buffer open across the phase change now and then.
			if ($urandom_range(0, 1) == 1) begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++)
					queue_frame(pick_sample(32768), pick_sample(32768), 1'b0);
			end
		end

		drain_and_settle();
		if (error_count == 0)
			$display("block_mean_sliding_max_level verification clean");
		else
			$display("block_mean_sliding_max_level verification failed");
		$finish;
	end

endmodule
